// ===== rtl/core/rvexu_pkg.sv =====
// Shared types, constants and helpers for the RV32I subset execute unit.
`default_nettype none

package rvexu_pkg;

    // Register file and data memory geometry.
    localparam int REG_COUNT = 32;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int MEM_WORDS = 1024;
    localparam int MEM_IDX_W = $clog2(MEM_WORDS);
    localparam logic [31:0] MEM_WORDS_W = 32'(MEM_WORDS);

    // Program counter value after reset.
    localparam logic [31:0] RESET_PC = 32'd1000;

    // Instruction classes.
    typedef enum logic [2:0] {
        REQ_ALU_REG = 3'd0,
        REQ_ALU_IMM = 3'd1,
        REQ_LOAD    = 3'd2,
        REQ_JALR    = 3'd3,
        REQ_STORE   = 3'd4,
        REQ_BRANCH  = 3'd5,
        REQ_JAL     = 3'd6,
        REQ_EXIT    = 3'd7
    } req_type_t;

    // ALU funct3 codes.
    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_XOR = 3'd4;
    localparam logic [2:0] F3_SR  = 3'd5;
    localparam logic [2:0] F3_OR  = 3'd6;
    localparam logic [2:0] F3_AND = 3'd7;

    // Memory, jump and branch funct3 codes.
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_JALR = 3'd0;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;

    // Reset contents of a register: x1 to x6 hold their own index, the rest zero.
    function automatic logic [31:0] rf_init(input logic [REG_IDX_W-1:0] idx);
        logic [31:0] val;
        val = 32'd0;
        if (idx >= REG_IDX_W'(1) && idx <= REG_IDX_W'(6))
        begin
            val = 32'(idx);
        end
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rv32i_subset_execute_unit.sv =====
// Execute unit for an RV32I subset with register file, data memory and PC.
// An instruction is registered into the execute stage, then into the result register.
// Throughput: one instruction per cycle unless out_ready stalls; register results
// of the previous instruction, loads included, are forwarded from write-back.
// Reset: PC goes to 1000 and the register file takes its reset values at once;
// the data memory is then cleared one word a cycle, all 1024 words, with no input.
`default_nettype none

module rv32i_subset_execute_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Configuration: start PC.
    input  wire logic               cfg_wr_en,
    input  wire logic [31:0]        cfg_wr_data,
    // Instruction channel.
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         req_type,
    input  wire logic [2:0]         funct3,
    input  wire logic               alt_op,
    input  wire logic [4:0]         dest_reg,
    input  wire logic [4:0]         src1_reg,
    input  wire logic [4:0]         src2_reg,
    input  wire logic signed [20:0] immediate,
    // Result channel.
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [31:0]             exec_pc,
    output logic [31:0]             next_pc,
    output logic                    branch_taken,
    output logic                    mem_fault,
    output logic                    bad_op,
    output logic                    halted
);

    import rvexu_pkg::*;

    // Architectural state.
    logic [31:0]                 pc_reg;
    logic                        halt_flag_reg;
    logic [31:0]                 rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0]        rf_valid_reg;
    logic [31:0]                 data_mem [MEM_WORDS];
    logic [31:0]                 mem_rdata_reg;

    // Memory clearing pass.
    logic                        clr_active_reg;
    logic [MEM_IDX_W-1:0]        clr_cnt_reg;

    // Execute stage.
    logic                        ex_valid_reg;
    req_type_t                   ex_type_reg;
    logic [2:0]                  ex_f3_reg;
    logic                        ex_alt_reg;
    logic [REG_IDX_W-1:0]        ex_rd_reg;
    logic [REG_IDX_W-1:0]        ex_src1_reg;
    logic [REG_IDX_W-1:0]        ex_src2_reg;
    logic [31:0]                 ex_imm_reg;
    logic                        ex_rfv1_reg;
    logic                        ex_rfv2_reg;
    logic                        ex_byp1_reg;
    logic                        ex_byp2_reg;
    logic [31:0]                 ex_byp_data1_reg;
    logic [31:0]                 ex_byp_data2_reg;
    logic [31:0]                 rf_rdata1_reg;
    logic [31:0]                 rf_rdata2_reg;

    // Write-back stage.
    logic                        wb_valid_reg;
    logic                        wb_load_reg;
    logic [REG_IDX_W-1:0]        wb_rd_reg;
    logic [31:0]                 wb_data_reg;
    logic [31:0]                 wb_wdata;

    // Result register.
    logic                        out_valid_reg;
    logic [31:0]                 out_exec_pc_reg;
    logic [31:0]                 out_next_pc_reg;
    logic                        out_taken_reg;
    logic                        out_fault_reg;
    logic                        out_bad_reg;
    logic                        out_halted_reg;

    // Handshake and control.
    logic                        in_xfer;
    logic                        ex_advance;
    logic                        ex_hold;
    logic                        acc_byp1;
    logic                        acc_byp2;
    logic                        wb_fwd1;
    logic                        wb_fwd2;

    // Execute stage results.
    logic [31:0]                 op_a;
    logic [31:0]                 op_b;
    logic [31:0]                 alu_b;
    logic                        alt_eff;
    logic [4:0]                  shamt;
    logic [31:0]                 alu_res;
    logic                        alu_ok;
    logic [31:0]                 pc_plus4;
    logic [31:0]                 pc_plus_imm;
    logic [31:0]                 ea_sum;
    logic                        ea_fault;
    logic [MEM_IDX_W-1:0]        ea_idx;
    logic                        br_cond;
    logic [31:0]                 ex_npc;
    logic                        ex_taken;
    logic                        ex_fault;
    logic                        ex_bad;
    logic                        ex_exit;
    logic                        ex_wr_en;
    logic                        ex_wr_load;
    logic [31:0]                 ex_wr_data;
    logic                        ex_store;

    // Memory port.
    logic                        mem_we;
    logic [MEM_IDX_W-1:0]        mem_addr;
    logic [31:0]                 mem_wdata;

    // Stage movement: the result register parts execute from the output side.
    assign ex_advance = ex_valid_reg && (!out_valid_reg || out_ready);
    assign ex_hold    = ex_valid_reg && !ex_advance;
    assign in_ready   = !clr_active_reg && (!ex_valid_reg || ex_advance);
    assign in_xfer    = in_valid && in_ready;

    // Write-back data: a load takes the word read from memory last cycle.
    assign wb_wdata = wb_load_reg ? mem_rdata_reg : wb_data_reg;

    // Bypass of the write that lands at the same edge as the register read.
    assign acc_byp1 = wb_valid_reg && (wb_rd_reg == src1_reg);
    assign acc_byp2 = wb_valid_reg && (wb_rd_reg == src2_reg);

    // Forwarding from the write-back stage into execute.
    assign wb_fwd1 = wb_valid_reg && (wb_rd_reg == ex_src1_reg);
    assign wb_fwd2 = wb_valid_reg && (wb_rd_reg == ex_src2_reg);

    // Operand selection.
    always_comb
    begin
        if (wb_fwd1)
        begin
            op_a = wb_wdata;
        end
        else if (ex_byp1_reg)
        begin
            op_a = ex_byp_data1_reg;
        end
        else if (ex_rfv1_reg)
        begin
            op_a = rf_rdata1_reg;
        end
        else
        begin
            op_a = rf_init(ex_src1_reg);
        end

        if (wb_fwd2)
        begin
            op_b = wb_wdata;
        end
        else if (ex_byp2_reg)
        begin
            op_b = ex_byp_data2_reg;
        end
        else if (ex_rfv2_reg)
        begin
            op_b = rf_rdata2_reg;
        end
        else
        begin
            op_b = rf_init(ex_src2_reg);
        end
    end

    // ALU.
    always_comb
    begin
        alu_b   = (ex_type_reg == REQ_ALU_IMM) ? ex_imm_reg : op_b;
        shamt   = alu_b[4:0];
        alt_eff = ex_alt_reg;
        if (ex_type_reg == REQ_ALU_IMM && ex_f3_reg != F3_SLL && ex_f3_reg != F3_SR)
        begin
            alt_eff = 1'b0;
        end
        alu_res = 32'd0;
        alu_ok  = 1'b1;
        unique case (ex_f3_reg)
            F3_ADD:  alu_res = alt_eff ? (op_a - alu_b) : (op_a + alu_b);
            F3_SLL:
            begin
                alu_res = op_a << shamt;
                alu_ok  = !alt_eff;
            end
            F3_XOR:
            begin
                alu_res = op_a ^ alu_b;
                alu_ok  = !alt_eff;
            end
            F3_SR:   alu_res = alt_eff ? 32'($signed(op_a) >>> shamt) : (op_a >> shamt);
            F3_OR:
            begin
                alu_res = op_a | alu_b;
                alu_ok  = !alt_eff;
            end
            F3_AND:
            begin
                alu_res = op_a & alu_b;
                alu_ok  = !alt_eff;
            end
            default: alu_ok = 1'b0;
        endcase
    end

    // Address, branch condition and targets.
    always_comb
    begin
        pc_plus4    = pc_reg + 32'd4;
        pc_plus_imm = pc_reg + ex_imm_reg;
        ea_sum      = op_a + ex_imm_reg;
        ea_fault    = {2'b00, ea_sum[31:2]} >= MEM_WORDS_W;
        ea_idx      = ea_sum[MEM_IDX_W+1:2];
        br_cond     = 1'b0;
        unique case (ex_f3_reg)
            F3_BEQ:  br_cond = (op_a == op_b);
            F3_BNE:  br_cond = (op_a != op_b);
            F3_BLT:  br_cond = ($signed(op_a) < $signed(op_b));
            F3_BGE:  br_cond = ($signed(op_a) >= $signed(op_b));
            default: br_cond = 1'b0;
        endcase
    end

    // Instruction decode and effects.
    always_comb
    begin
        ex_npc     = pc_plus4;
        ex_taken   = 1'b0;
        ex_fault   = 1'b0;
        ex_bad     = 1'b0;
        ex_exit    = 1'b0;
        ex_wr_en   = 1'b0;
        ex_wr_load = 1'b0;
        ex_wr_data = alu_res;
        ex_store   = 1'b0;
        if (halt_flag_reg)
        begin
            ex_npc = pc_reg;
        end
        else
        begin
            unique case (ex_type_reg)
                REQ_ALU_REG, REQ_ALU_IMM:
                begin
                    ex_bad   = !alu_ok;
                    ex_wr_en = alu_ok;
                end
                REQ_LOAD, REQ_STORE:
                begin
                    if (ex_f3_reg != F3_WORD)
                    begin
                        ex_bad = 1'b1;
                    end
                    else if (ea_fault)
                    begin
                        ex_fault = 1'b1;
                    end
                    else if (ex_type_reg == REQ_LOAD)
                    begin
                        ex_wr_en   = 1'b1;
                        ex_wr_load = 1'b1;
                    end
                    else
                    begin
                        ex_store = 1'b1;
                    end
                end
                REQ_JALR:
                begin
                    if (ex_f3_reg != F3_JALR)
                    begin
                        ex_bad = 1'b1;
                    end
                    else
                    begin
                        ex_npc     = {ea_sum[31:1], 1'b0};
                        ex_taken   = 1'b1;
                        ex_wr_en   = 1'b1;
                        ex_wr_data = pc_plus4;
                    end
                end
                REQ_BRANCH:
                begin
                    ex_bad = (ex_f3_reg != F3_BEQ) && (ex_f3_reg != F3_BNE)
                             && (ex_f3_reg != F3_BLT) && (ex_f3_reg != F3_BGE);
                    if (br_cond)
                    begin
                        ex_npc   = pc_plus_imm;
                        ex_taken = 1'b1;
                    end
                end
                REQ_JAL:
                begin
                    ex_npc     = pc_plus_imm;
                    ex_taken   = 1'b1;
                    ex_wr_en   = 1'b1;
                    ex_wr_data = pc_plus4;
                end
                default:
                begin
                    ex_exit = 1'b1;
                    ex_npc  = pc_reg;
                end
            endcase
        end
    end

    // Data memory port: the clearing pass owns it after reset.
    assign mem_we    = clr_active_reg || (ex_advance && ex_store);
    assign mem_addr  = clr_active_reg ? clr_cnt_reg : ea_idx;
    assign mem_wdata = clr_active_reg ? 32'd0 : op_b;

    // Data memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            data_mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= data_mem[mem_addr];
    end

    // Register file storage with registered reads at transfer time.
    always_ff @(posedge clk)
    begin
        if (wb_valid_reg)
        begin
            rf_mem[wb_rd_reg] <= wb_wdata;
        end
        if (in_xfer)
        begin
            rf_rdata1_reg <= rf_mem[src1_reg];
            rf_rdata2_reg <= rf_mem[src2_reg];
        end
    end

    // Register valid bits: an entry never written reads as its reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
        end
        else if (wb_valid_reg)
        begin
            rf_valid_reg[wb_rd_reg] <= 1'b1;
        end
    end

    // Clearing pass counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + MEM_IDX_W'(1);
            if (clr_cnt_reg == MEM_IDX_W'(MEM_WORDS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // PC and halt flag; a configuration write reloads the PC.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= RESET_PC;
            halt_flag_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            pc_reg <= cfg_wr_data;
        end
        else if (ex_advance)
        begin
            pc_reg <= ex_npc;
            if (ex_exit)
            begin
                halt_flag_reg <= 1'b1;
            end
        end
    end

    // Execute stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            ex_valid_reg <= 1'b1;
        end
        else if (ex_advance)
        begin
            ex_valid_reg <= 1'b0;
        end
    end

    // Execute stage payload and operand bypass state.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ex_type_reg      <= req_type_t'(req_type);
            ex_f3_reg        <= funct3;
            ex_alt_reg       <= alt_op;
            ex_rd_reg        <= dest_reg;
            ex_src1_reg      <= src1_reg;
            ex_src2_reg      <= src2_reg;
            ex_imm_reg       <= 32'(immediate);
            ex_rfv1_reg      <= rf_valid_reg[src1_reg];
            ex_rfv2_reg      <= rf_valid_reg[src2_reg];
            ex_byp1_reg      <= acc_byp1;
            ex_byp2_reg      <= acc_byp2;
            ex_byp_data1_reg <= wb_wdata;
            ex_byp_data2_reg <= wb_wdata;
        end
        else if (ex_hold)
        begin
            // Keep a forwarded value once the write-back stage has drained.
            if (wb_fwd1)
            begin
                ex_byp1_reg      <= 1'b1;
                ex_byp_data1_reg <= wb_wdata;
            end
            if (wb_fwd2)
            begin
                ex_byp2_reg      <= 1'b1;
                ex_byp_data2_reg <= wb_wdata;
            end
        end
    end

    // Write-back stage control; x0 is never written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            wb_valid_reg <= ex_advance && ex_wr_en && (ex_rd_reg != '0);
        end
    end

    // Write-back stage payload.
    always_ff @(posedge clk)
    begin
        if (ex_advance)
        begin
            wb_load_reg <= ex_wr_load;
            wb_rd_reg   <= ex_rd_reg;
            wb_data_reg <= ex_wr_data;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ex_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (ex_advance)
        begin
            out_exec_pc_reg <= pc_reg;
            out_next_pc_reg <= ex_npc;
            out_taken_reg   <= ex_taken;
            out_fault_reg   <= ex_fault;
            out_bad_reg     <= ex_bad;
            out_halted_reg  <= halt_flag_reg || ex_exit;
        end
    end

    assign out_valid    = out_valid_reg;
    assign exec_pc      = out_exec_pc_reg;
    assign next_pc      = out_next_pc_reg;
    assign branch_taken = out_taken_reg;
    assign mem_fault    = out_fault_reg;
    assign bad_op       = out_bad_reg;
    assign halted       = out_halted_reg;

endmodule

`default_nettype wire
